// File: rtl/gn3o_pkg.sv
// gn3o_pkg: shared types and constants for the 3d gradient noise block
// no dependencies
`timescale 1ns / 1ps
package gn3o_pkg;
	localparam int ONE_Q16 = 65536;

	localparam logic [0:0] CFG_OCTAVES     = 1'd0;
	localparam logic [0:0] CFG_PERSISTENCE = 1'd1;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_EVAL = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_OCT,
		ST_FADE,
		ST_HA,
		ST_HB,
		ST_HC,
		ST_GRAD,
		ST_LERP,
		ST_ACC,
		ST_DIV,
		ST_OUT
	} state_t;

	// gradient for one corner, h is the low 4 hash bits, offsets are 18-bit signed
	function automatic logic signed [18:0] grad(input logic [3:0] h,
		input logic signed [17:0] x, input logic signed [17:0] y,
		input logic signed [17:0] z);
		logic signed [18:0] u;
		logic signed [18:0] v;
		u = (h < 4'd8) ? 19'(x) : 19'(y);
		v = (h < 4'd4) ? 19'(y) : ((h == 4'd12 || h == 4'd14) ? 19'(x) : 19'(z));
		if (h[0]) u = -u;
		if (h[1]) v = -v;
		return u + v;
	endfunction
endpackage

// File: rtl/gn3o_div.sv
// gn3o_div: restoring divider, one quotient bit per cycle
// depends on gn3o_pkg
`timescale 1ns / 1ps
module gn3o_div
	import gn3o_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [47:0] dividend,
	input  logic [19:0] divisor,
	output logic        done,
	output logic [16:0] quotient
);
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [47:0] num_q;
	logic [20:0] rem_q;
	logic [16:0] quo_q;
	logic [20:0] trial;

	assign trial = {rem_q[19:0], num_q[47]} - {1'b0, divisor};

	// shift-subtract loop, quotient saturates above 17 bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd48;
				num_q  <= dividend;
				rem_q  <= '0;
				quo_q  <= '0;
			end else if (busy_q) begin
				num_q <= {num_q[46:0], 1'b0};
				if (!trial[20]) begin
					rem_q <= trial;
					quo_q <= (quo_q == 17'h1ffff) ? quo_q : {quo_q[15:0], 1'b1} | {quo_q[16], 16'd0};
				end else begin
					rem_q <= {rem_q[19:0], num_q[47]};
					quo_q <= quo_q[16] ? quo_q : {quo_q[15:0], 1'b0};
				end
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end
	assign quotient = quo_q;
endmodule

// File: rtl/gradient_noise_3d_octaves.sv
// gradient_noise_3d_octaves: improved 3d gradient noise summed over octaves
// sequence: a load is written straight into the table; an evaluation runs the fade, hash, gradient,
// lerp and accumulate steps serially once per octave, then the final divide and output
// throughput: one request at a time; a waiting result holds the next evaluation at its last step
// reset: asynchronous active low, clears control state; the permutation table
// has a valid bit per entry so it reads as the identity right after reset
`timescale 1ns / 1ps
module gradient_noise_3d_octaves
	import gn3o_pkg::*;
#(
	parameter int TABLE_SIZE  = 256,
	parameter int MAX_OCTAVES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        op,
	input  logic [31:0] coord_x,
	input  logic [31:0] coord_y,
	input  logic [31:0] coord_z,
	input  logic [7:0]  entry_index,
	input  logic [7:0]  entry_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] noise_value,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	localparam int AW = $clog2(TABLE_SIZE);
	localparam int OW = $clog2(MAX_OCTAVES + 1);

	state_t state_q, state_d;

	// configuration
	logic [3:0]  oct_cfg_q;
	logic [15:0] pers_q;
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oct_cfg_q <= 4'd1;
			pers_q    <= 16'd32768;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_OCTAVES:     oct_cfg_q <= cfg_data[3:0];
				CFG_PERSISTENCE: pers_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// permutation memory, one write port and one registered read port
	logic [7:0]            mem [TABLE_SIZE];
	logic [TABLE_SIZE-1:0] vld_q;
	logic [AW-1:0]         raddr, raddr_q;
	logic [AW-1:0]         waddr;
	logic [7:0]            rd_raw, rdata;
	logic                  rvld_q;
	logic                  wr_en;

	assign waddr = AW'(entry_index);

	always_ff @(posedge clk) begin
		if (wr_en) mem[waddr] <= entry_value;
		rd_raw <= mem[raddr];
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			rvld_q  <= 1'b0;
			raddr_q <= '0;
		end else begin
			if (wr_en) vld_q[waddr] <= 1'b1;
			rvld_q  <= vld_q[raddr];
			raddr_q <= raddr;
		end
	end
	assign rdata = rvld_q ? rd_raw : 8'(raddr_q);

	// item registers
	logic [31:0] cx_q, cy_q, cz_q;
	logic [OW-1:0] noct_q, oi_q;
	logic [AW-1:0] xi_q, yi_q, zi_q;
	logic [15:0] xf_q, yf_q, zf_q;
	logic [16:0] fu_q, fv_q, fw_q;
	logic [1:0]  fsel_q;
	logic [4:0]  step_q;
	logic [7:0]  hA_q [2];
	logic [7:0]  hB_q [8];
	logic signed [18:0] g_q [8];
	logic signed [20:0] lv_q [7];
	logic [2:0]  lsel_q;
	logic signed [47:0] total_q;
	logic [19:0] sum_q;
	logic [16:0] amp_q;
	logic [16:0] res_q;

	// output register
	logic out_v_q;
	logic [15:0] out_d_q;
	assign out_valid   = out_v_q;
	assign noise_value = out_d_q;

	assign in_ready = (state_q == ST_IDLE);
	logic acc_in;
	assign acc_in = in_valid && in_ready;
	assign wr_en  = acc_in && (op == OP_LOAD);

	// scaled coordinates of current octave
	logic [63:0] sx, sy, sz;
	assign sx = {{32{cx_q[31]}}, cx_q} << oi_q;
	assign sy = {{32{cy_q[31]}}, cy_q} << oi_q;
	assign sz = {{32{cz_q[31]}}, cz_q} << oi_q;

	// fade unit, one axis at a time, registered chain
	logic [15:0] ft;
	logic [31:0] fm1;
	logic [15:0] t2_q, t3_q;
	logic signed [22:0] fp;
	logic signed [40:0] fm3;
	assign ft  = (fsel_q == 2'd0) ? xf_q : (fsel_q == 2'd1) ? yf_q : zf_q;
	assign fm1 = 32'(ft) * 32'(ft);
	assign fp  = 23'sd6 * $signed({7'd0, t2_q}) - 23'sd15 * $signed({7'd0, ft}) + 23'sd655360;
	assign fm3 = $signed({25'd0, t3_q}) * 41'(fp);

	// hash address sequencing: step 0..1 A, 0..7 B/C per corner
	logic [AW-1:0] cxi, cyi, czi;
	logic [2:0] cidx;
	assign cidx = step_q[2:0];
	assign cxi = xi_q + AW'(cidx[0]);
	assign cyi = yi_q + AW'(cidx[1]);
	assign czi = zi_q + AW'(cidx[2]);

	always_comb begin
		raddr = '0;
		unique case (state_q)
			ST_HA:  raddr = (step_q < 5'd2) ? AW'(xi_q + AW'(step_q[0])) : '0;
			ST_HB:  raddr = AW'(hA_q[cidx[0]]) + cyi;
			ST_HC:  raddr = AW'(hB_q[cidx]) + czi;
			default: raddr = '0;
		endcase
	end

	// lerp unit
	logic signed [20:0] la, lb;
	logic signed [16:0] lw;
	logic signed [38:0] lm;
	always_comb begin
		unique case (lsel_q)
			3'd0: begin la = 21'(g_q[0]); lb = 21'(g_q[1]); lw = fu_q; end
			3'd1: begin la = 21'(g_q[2]); lb = 21'(g_q[3]); lw = fu_q; end
			3'd2: begin la = 21'(g_q[4]); lb = 21'(g_q[5]); lw = fu_q; end
			3'd3: begin la = 21'(g_q[6]); lb = 21'(g_q[7]); lw = fu_q; end
			3'd4: begin la = lv_q[0]; lb = lv_q[1]; lw = fv_q; end
			3'd5: begin la = lv_q[2]; lb = lv_q[3]; lw = fv_q; end
			default: begin la = lv_q[4]; lb = lv_q[5]; lw = fw_q; end
		endcase
		lm = 39'($signed({1'b0, lw})) * 39'(lb - la);
	end
	logic signed [20:0] lres;
	assign lres = la + 21'(lm >>> 16);

	// sample and accumulate, sample may dip below zero
	logic signed [21:0] samp;
	logic signed [39:0] samp_amp;
	logic [32:0] amp_next;
	assign samp     = (22'(lv_q[6]) + 22'(ONE_Q16)) >>> 1;
	assign samp_amp = 40'(samp) * 40'($signed({1'b0, amp_q}));
	assign amp_next = 33'(amp_q) * 33'(pers_q);

	// divider
	logic div_start, div_done;
	logic [16:0] div_q;
	gn3o_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(total_q),
		.divisor (sum_q),
		.done    (div_done),
		.quotient(div_q)
	);
	assign div_start = (state_q == ST_ACC) && (oi_q + OW'(1) == noct_q) && (step_q == 5'd1);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (acc_in && op == OP_EVAL) state_d = ST_OCT;
			ST_OCT:  state_d = ST_FADE;
			ST_FADE: if (step_q == 5'd8) state_d = ST_HA;
			ST_HA:   if (step_q == 5'd2) state_d = ST_HB;
			ST_HB:   if (step_q == 5'd8) state_d = ST_HC;
			ST_HC:   if (step_q == 5'd8) state_d = ST_GRAD;
			ST_GRAD: state_d = ST_LERP;
			ST_LERP: if (lsel_q == 3'd6) state_d = ST_ACC;
			ST_ACC:  if (step_q == 5'd1)
					state_d = (oi_q + OW'(1) == noct_q) ? ST_DIV : ST_OCT;
			ST_DIV:  if (div_done) state_d = ST_OUT;
			ST_OUT:  if (!out_v_q) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// datapath sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_v_q <= 1'b0;
			step_q  <= '0;
			oi_q    <= '0;
			noct_q  <= '0;
			fsel_q  <= '0;
			lsel_q  <= '0;
		end else begin
			state_q <= state_d;
			if (out_v_q && out_ready) out_v_q <= 1'b0;
			if (state_d != state_q) step_q <= '0;
			else step_q <= step_q + 5'd1;
			unique case (state_q)
				ST_IDLE: if (acc_in && op == OP_EVAL) begin
					cx_q <= coord_x; cy_q <= coord_y; cz_q <= coord_z;
					oi_q <= '0;
					if (oct_cfg_q == 4'd0) noct_q <= OW'(1);
					else if (32'(oct_cfg_q) > MAX_OCTAVES) noct_q <= OW'(MAX_OCTAVES);
					else noct_q <= OW'(oct_cfg_q);
					total_q <= '0;
					sum_q   <= '0;
					amp_q   <= 17'(ONE_Q16);
				end
				ST_OCT: begin
					xi_q <= sx[16 +: AW]; yi_q <= sy[16 +: AW]; zi_q <= sz[16 +: AW];
					xf_q <= sx[15:0]; yf_q <= sy[15:0]; zf_q <= sz[15:0];
					fsel_q <= 2'd0;
				end
				ST_FADE: begin
					// each axis in turn: t2, then t3, then the product
					unique case (step_q)
						5'd0, 5'd3, 5'd6: t2_q <= fm1[31:16];
						5'd1, 5'd4, 5'd7: t3_q <= 16'((32'(t2_q) * 32'(ft)) >> 16);
						default: begin
							unique case (fsel_q)
								2'd0: fu_q <= (fm3 >>> 16) > 41'sd65536 ? 17'd65536 : 17'(fm3 >>> 16);
								2'd1: fv_q <= (fm3 >>> 16) > 41'sd65536 ? 17'd65536 : 17'(fm3 >>> 16);
								default: fw_q <= (fm3 >>> 16) > 41'sd65536 ? 17'd65536 : 17'(fm3 >>> 16);
							endcase
							fsel_q <= fsel_q + 2'd1;
						end
					endcase
				end
				// hash read data lands in the cycle after the address
				ST_HA: if (step_q >= 5'd1) hA_q[1'(step_q - 5'd1)] <= rdata;
				ST_HB: if (step_q >= 5'd1) hB_q[3'(step_q - 5'd1)] <= rdata;
				ST_HC: if (step_q >= 5'd1) hB_q[3'(step_q - 5'd1)] <= rdata;
				default: ;
			endcase
			if (state_q == ST_GRAD) begin
				for (int c = 0; c < 8; c++) begin
					g_q[c] <= grad(hB_q[c][3:0],
						c[0] ? $signed({2'b11, xf_q}) : $signed({2'b00, xf_q}),
						c[1] ? $signed({2'b11, yf_q}) : $signed({2'b00, yf_q}),
						c[2] ? $signed({2'b11, zf_q}) : $signed({2'b00, zf_q}));
				end
				lsel_q <= '0;
			end
			if (state_q == ST_LERP) begin
				lv_q[lsel_q] <= lres;
				lsel_q <= lsel_q + 3'd1;
			end
			if (state_q == ST_ACC && step_q == 5'd0) begin
				total_q <= total_q + 48'(samp_amp);
				sum_q   <= sum_q + 20'(amp_q);
			end
			if (state_q == ST_ACC && step_q == 5'd1) begin
				amp_q <= 17'(amp_next >> 16);
				oi_q  <= oi_q + OW'(1);
			end
			// a total at or below zero maps to zero
			if (state_q == ST_DIV && div_done) res_q <= total_q[47] ? 17'd0 : div_q;
			if (state_q == ST_OUT && !out_v_q) begin
				out_v_q <= 1'b1;
				out_d_q <= res_q[16] ? 16'hffff : res_q[15:0];
			end
		end
	end
endmodule

// File: rtl/gn3o_checker.sv
// gn3o_checker: port-level checks for gradient_noise_3d_octaves
// depends on the top level ports only
`timescale 1ns / 1ps
module gn3o_checker (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [15:0] noise_value
);
	// result holds while stalled
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(noise_value))
		else $error("result dropped while stalled");
	// a taken result is never followed by another on the next cycle
	a_once: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |=> !out_valid)
		else $error("result repeated");
	// core is back to idle when a result appears
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("result raised while core busy");
	// idle with no result right after reset
	a_rst: assert property (@(posedge clk) !arst_n |=> !out_valid && in_ready)
		else $error("not idle after reset");
endmodule

bind gradient_noise_3d_octaves gn3o_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .noise_value(noise_value));
